// ===== rtl/core/b64se_pkg.sv =====
// Shared types, constants and the symbol lookup for the base64 stream encoder.
`default_nettype none

package b64se_pkg;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [5:0] SEXTET_MASK = 6'h3F;

    // Number of significant characters in a group, the rest are padding.
    localparam logic [2:0] SIG_ONE_BYTE  = 3'd2;
    localparam logic [2:0] SIG_TWO_BYTES = 3'd3;
    localparam logic [2:0] SIG_FULL      = 3'd4;

    // One closed group of up to three bytes, zero filled, handed from the front end to the back end.
    typedef struct packed {
        logic [23:0] bits;
        logic [2:0]  sig;
        logic        last;
    } group_t;

    // Map a 6-bit value onto the standard alphabet A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v & SEXTET_MASK};
        if (w < 8'd26) begin
            b64_symbol = 8'h41 + w;
        end else if (w < 8'd52) begin
            b64_symbol = 8'h61 + (w - 8'd26);
        end else if (w < 8'd62) begin
            b64_symbol = 8'h30 + (w - 8'd52);
        end else if (w == 8'd62) begin
            b64_symbol = 8'h2B;
        end else begin
            b64_symbol = 8'h2F;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/base64_stream_encoder_top.sv =====
// Top level of the base64 stream encoder: front end, group queue, back end.
//
// Input channel (s_): one raw byte per item in s_data_byte, with s_last_byte
// set on the final byte of a message. Output channel (m_): one ASCII
// character per item in m_out_char, with m_last_char set on the final
// character of the encoded message. Both channels use valid/ready.
//
// Every three bytes give four characters from the standard alphabet. A
// message that ends on a group of one or two bytes is zero filled and padded
// with "==" or "=" so that every message yields a multiple of four items.
//
// Path: the group closed by an accepted byte is written into the queue and
// then loaded into the back end once the back end is free; its first
// character is valid once it is loaded. The back end sends one character
// per cycle while the receiver is ready, and loads the next group as it
// sends the last character of the current one, so sustained input is set by
// the single-character output port. The front end takes a byte in every cycle
// while the two-entry group queue has room, so bursts are absorbed while the
// back end drains earlier groups.
//
// Reset (aresetn low, synchronous) drops held bytes, queued groups and the
// character in flight. When the receiver stalls, the current character holds
// steady, the queue fills, and s_ready falls once it holds two groups.
`default_nettype none

module base64_stream_encoder_top
    import b64se_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_char,
    output logic             m_last_char
);

    // Group records travel between the stages as one packed struct.
    group_t push_data;
    group_t pop_data;
    logic   push;
    logic   full;
    logic   pop;
    logic   pop_valid;

    b64se_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .q_full      (full),
        .q_push      (push),
        .q_data      (push_data)
    );

    b64se_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    b64se_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (pop_valid),
        .q_data      (pop_data),
        .q_pop       (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last_char (m_last_char)
    );

endmodule

`default_nettype wire

// ===== rtl/core/b64se_front.sv =====
// Front end: collects input bytes into groups of up to three and closes them.
`default_nettype none

module b64se_front
    import b64se_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    input  wire logic        q_full,
    output logic             q_push,
    output group_t           q_data
);

    logic [15:0] pending_bytes_reg, pending_bytes_next;
    logic [1:0]  pending_count_reg, pending_count_next;
    logic        accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pending_bytes_next = pending_bytes_reg;
        pending_count_next = pending_count_reg;
        q_push             = 1'b0;
        q_data.bits        = {s_data_byte, 16'h0000};
        q_data.sig         = SIG_ONE_BYTE;
        q_data.last        = 1'b1;
        unique case (pending_count_reg)
            2'd1: begin
                q_data.bits = {pending_bytes_reg[15:8], s_data_byte, 8'h00};
                q_data.sig  = SIG_TWO_BYTES;
                if (accept) begin
                    if (s_last_byte) begin
                        q_push             = 1'b1;
                        pending_bytes_next = 16'h0000;
                        pending_count_next = 2'd0;
                    end else begin
                        pending_bytes_next = {pending_bytes_reg[15:8], s_data_byte};
                        pending_count_next = 2'd2;
                    end
                end
            end
            2'd2: begin
                q_data.bits = {pending_bytes_reg, s_data_byte};
                q_data.sig  = SIG_FULL;
                q_data.last = s_last_byte;
                if (accept) begin
                    q_push             = 1'b1;
                    pending_bytes_next = 16'h0000;
                    pending_count_next = 2'd0;
                end
            end
            default: begin
                // An empty holder, or the unreachable count of three.
                if (accept) begin
                    if (s_last_byte) begin
                        q_push             = 1'b1;
                        pending_bytes_next = 16'h0000;
                        pending_count_next = 2'd0;
                    end else begin
                        pending_bytes_next = {s_data_byte, 8'h00};
                        pending_count_next = 2'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_bytes_reg <= 16'h0000;
            pending_count_reg <= 2'd0;
        end else begin
            pending_bytes_reg <= pending_bytes_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/b64se_fifo.sv =====
// Two-entry queue of closed groups between the front and back ends.
`default_nettype none

module b64se_fifo
    import b64se_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  group_t      push_data,
    output logic        full,
    input  wire logic   pop,
    output logic        pop_valid,
    output group_t      pop_data
);

    group_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/b64se_back.sv =====
// Back end: turns one queued group into four output characters.
`default_nettype none

module b64se_back
    import b64se_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  group_t           q_data,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_char,
    output logic             m_last_char
);

    group_t     group_reg;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       final_char, advance;
    logic [5:0] sextet;

    assign final_char = (idx_reg == 2'd3);
    assign advance    = busy_reg && m_ready;
    assign q_pop      = q_valid && (!busy_reg || (advance && final_char));

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (q_pop) begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end else if (advance) begin
            idx_next = idx_reg + 2'd1;
            if (final_char) begin
                busy_next = 1'b0;
            end
        end
    end

    always_comb begin
        unique case (idx_reg)
            2'd0:    sextet = group_reg.bits[23:18];
            2'd1:    sextet = group_reg.bits[17:12];
            2'd2:    sextet = group_reg.bits[11:6];
            default: sextet = group_reg.bits[5:0];
        endcase
    end

    assign m_valid     = busy_reg;
    assign m_out_char  = ({1'b0, idx_reg} < group_reg.sig) ? b64_symbol(sextet) : PAD_CHAR;
    assign m_last_char = group_reg.last && final_char;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            group_reg <= q_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/b64se_checker.sv =====
// Port-level checks of the base64 stream encoder and their binding.
`default_nettype none

module b64se_checker
    import b64se_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [7:0] s_data_byte,
    input wire logic       s_last_byte,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_char,
    input wire logic       m_last_char
);

    // A waiting input item keeps its byte and flag until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data_byte) && $stable(s_last_byte))
        else $error("waiting input item changed");

    // A stalled output item holds its character and flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) && $stable(m_last_char))
        else $error("stalled output item changed");

    // Every character is from the alphabet or is the pad character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_char >= 8'h41 && m_out_char <= 8'h5A) ||
                    (m_out_char >= 8'h61 && m_out_char <= 8'h7A) ||
                    (m_out_char >= 8'h30 && m_out_char <= 8'h39) ||
                    m_out_char == 8'h2B || m_out_char == 8'h2F ||
                    m_out_char == PAD_CHAR)
        else $error("output character outside the alphabet");

    // Padding only ends a message: a pad that is not last is followed at once by another.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_out_char == PAD_CHAR && !m_last_char
        |=> m_valid && m_out_char == PAD_CHAR)
        else $error("pad character not followed by pad");

    // The output side is quiet right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind base64_stream_encoder_top b64se_checker u_b64se_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_data_byte (s_data_byte),
    .s_last_byte (s_last_byte),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_char  (m_out_char),
    .m_last_char (m_last_char)
);

`default_nettype wire

// ===== test/tb_base64_stream_encoder_top.sv =====
// Self-checking testbench for the base64 stream encoder top level.
`timescale 1ns / 1ps

module tb_base64_stream_encoder_top;
    import b64se_pkg::*;

    // Cycles in a row with no item accepted on either channel before the
    // run is declared hung. The longest legal quiet stretch is a handful of
    // random stalls plus reset, so this leaves a wide margin.
    localparam int HANG_LIMIT   = 5000;
    // Cycles to keep watching the output after the last expected character.
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_BYTES  = 380;
    localparam int REPORT_LIMIT  = 10;

    // Predicts the encoded characters for every accepted byte and checks the
    // character stream against them in order.
    class b64_char_scoreboard;
        logic [15:0] held_bytes;
        logic [1:0]  held_count;
        // Each entry is {last_char, out_char}.
        logic [8:0]  expected_chars[$];
        int          fault_count;
        string       symbols;

        function new();
            held_bytes  = 16'h0000;
            held_count  = 2'd0;
            fault_count = 0;
            symbols = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        endfunction

        function void note_byte(input logic [7:0] b, input logic l);
            logic [23:0] grp;
            logic [5:0]  sextet;
            logic [7:0]  ch;
            int          sig;
            grp = 24'h000000;
            sig = 0;
            case (held_count)
                2'd1: begin
                    if (l) begin
                        grp = {held_bytes[15:8], b, 8'h00};
                        sig = 3;
                    end else begin
                        held_bytes[7:0] = b;
                        held_count      = 2'd2;
                    end
                end
                2'd2: begin
                    grp = {held_bytes, b};
                    sig = 4;
                end
                default: begin
                    if (l) begin
                        grp = {b, 16'h0000};
                        sig = 2;
                    end else begin
                        held_bytes = {b, 8'h00};
                        held_count = 2'd1;
                    end
                end
            endcase
            if (sig != 0) begin
                for (int k = 0; k < 4; k++) begin
                    sextet = grp[23 - 6 * k -: 6];
                    ch = (k < sig) ? symbols[sextet] : PAD_CHAR;
                    expected_chars.push_back({l && (k == 3), ch});
                end
                held_bytes = 16'h0000;
                held_count = 2'd0;
            end
        endfunction

        function void check_char(input logic [7:0] c, input logic l);
            logic [8:0] want;
            if (expected_chars.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected character %h last=%b", c, l);
                return;
            end
            want = expected_chars.pop_front();
            if (want !== {l, c}) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("character mismatch: expected %h last=%b, got %h last=%b",
                             want[7:0], want[8], c, l);
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_last_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_char;
    logic       m_last_char;

    // When set, neither the sender nor the receiver inserts idle cycles.
    bit no_idle;
    int quiet_cycles = 0;
    b64_char_scoreboard sb;

    base64_stream_encoder_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last_char (m_last_char)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Unless no_idle is set, the receiver stalls about six percent of the time. Its ready changes
    // only at the falling edge so that it is stable at every rising edge.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= no_idle || ($urandom_range(99) >= 6);
        end
    end

    // Every character accepted by the receiver is checked against the
    // oldest prediction. The handshake is sampled before the edge updates
    // the block, so the values seen are the ones the edge acted on.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_char(m_out_char, m_last_char);
    end

    // Hang detection: count cycles in which neither channel moves an item.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= HANG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offers one byte and returns once it has been accepted. A random number
    // of idle cycles may come first, with valid low. Valid stays high into
    // the next call when there is no gap, so back-to-back items need no
    // second assignment in the same time step.
    task automatic send_byte(input logic [7:0] b, input logic l);
        while (!no_idle && ($urandom_range(99) < 6)) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= l;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b, l);
    endtask

    // Holds the sender off until every predicted character has been seen,
    // which lets the group queue drain completely.
    task automatic drain_pause();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_chars.size() != 0)
            @(posedge aclk);
    endtask

    // Random byte with extra weight on the all-zero and all-one values.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    initial begin
        int sent;
        int msg_count;
        int len;
        sb           = new();
        no_idle      = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data_byte  = 8'h00;
        s_last_byte  = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed messages. A lone byte gives two symbols and a double pad,
        // two bytes give three symbols and a single pad, and a full group
        // gives four symbols with no pad. The extreme byte values reach the
        // first and last symbols of the alphabet, and the 0xFB 0xEF 0xBE
        // group maps every sextet onto the plus sign.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        // A full group that is not the end of its message, followed by a
        // closing group of one byte and then of two bytes.
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h4D, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b1);
        drain_pause();

        // Random messages, mostly short, with an occasional long one. A band
        // of messages in the middle runs with no idling on either side, and
        // now and then the sender waits for the output to drain completely.
        sent      = 0;
        msg_count = 0;
        while (sent < RANDOM_BYTES) begin
            no_idle = (msg_count >= 15) && (msg_count < 30);
            if ($urandom_range(9) == 0)
                len = $urandom_range(40, 13);
            else
                len = $urandom_range(7, 1);
            for (int i = 0; i < len; i++)
                send_byte(pick_byte(), i == len - 1);
            sent += len;
            msg_count++;
            if ($urandom_range(19) == 0)
                drain_pause();
        end
        no_idle = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_chars.size() != 0)
            @(posedge aclk);
        // Keep watching for a while so that any stray character is caught.
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (sb.fault_count == 0 && sb.expected_chars.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
